FILE: src/shs_pkg.sv
// ----------------------------------------------------------------------------
// shs_pkg: scan heartbeat supervisor shared definitions
// Command codes, event codes, phase codes and configuration constants.
// ----------------------------------------------------------------------------
package shs_pkg;

  localparam int unsigned FuncW  = 3;
  localparam int unsigned EvtW   = 3;
  localparam int unsigned PhaseW = 2;
  localparam int unsigned CfgW   = 16;
  localparam int unsigned CfgIdxW = 2;
  localparam int unsigned ElapW  = 32;
  localparam int unsigned ThrW   = 26;
  localparam int unsigned TgtW   = 16;

  localparam logic [9:0] MS_PER_S = 10'd1000;

  typedef enum logic [FuncW-1:0] {
    FUNC_START     = 3'd0,
    FUNC_GOTO      = 3'd1,
    FUNC_SCAN_TICK = 3'd2,
    FUNC_GOTO_TICK = 3'd3,
    FUNC_STATUS    = 3'd4
  } func_e;

  typedef enum logic [EvtW-1:0] {
    EV_NONE          = 3'd0,
    EV_STARTED       = 3'd1,
    EV_COMPLETED     = 3'd2,
    EV_TRIG_TIMEOUT  = 3'd3,
    EV_SCAN_TIMEOUT  = 3'd4,
    EV_GOTO_REJECTED = 3'd5,
    EV_GOTO_ENDED    = 3'd6
  } evt_e;

  typedef enum logic [PhaseW-1:0] {
    PH_IDLE      = 2'd0,
    PH_TRIGGERED = 2'd1,
    PH_RUNNING   = 2'd2
  } phase_e;

  typedef enum logic [CfgIdxW-1:0] {
    REG_BEAT_INTERVAL = 2'd0,
    REG_TRIG_TIMEOUT  = 2'd1,
    REG_SCAN_TIMEOUT  = 2'd2,
    REG_GOTO_TIMEOUT  = 2'd3
  } reg_idx_e;

  localparam logic [CfgW-1:0] BEAT_INTERVAL_RST = 16'd100;
  localparam logic [ThrW-1:0] TRIG_THR_RST      = 26'd10000;
  localparam logic [ThrW-1:0] SCAN_THR_RST      = 26'd600000;
  localparam logic [ThrW-1:0] GOTO_THR_RST      = 26'd10000;

  function automatic logic [ThrW-1:0] to_ms(input logic [CfgW-1:0] sec);
    return ThrW'(sec) * ThrW'(MS_PER_S);
  endfunction

endpackage

FILE: src/scan_heartbeat_supervisor.sv
// Path: a beat is held in the input register; its result in the result register.
// Throughput: one beat per cycle unless stalled; the state update for one beat fits
//   between the input register and the result register.
// Stalls: the input register holds while the result register is full and stalled.
// Reset: asynchronous; clears phase, timer, heartbeat, go-to and valid state (not the
//   command or result data) and loads the default intervals and timeouts. No clearing pass.
// ----------------------------------------------------------------------------
// scan_heartbeat_supervisor
// Heartbeat, scan and go-to supervision with elapsed-time timeouts.
// ----------------------------------------------------------------------------
module scan_heartbeat_supervisor (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [shs_pkg::CfgIdxW-1:0]   cfg_idx_i,
  input  logic [shs_pkg::CfgW-1:0]      cfg_wdata_i,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic [shs_pkg::FuncW-1:0]     func_i,
  input  logic                          status_flag_i,
  input  logic [shs_pkg::TgtW-1:0]      goto_value_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic                          send_telegram_o,
  output logic                          heartbeat_bit_o,
  output logic                          scan_enable_o,
  output logic                          goto_enable_o,
  output logic [shs_pkg::TgtW-1:0]      goto_target_o,
  output logic [shs_pkg::PhaseW-1:0]    phase_o,
  output logic [shs_pkg::EvtW-1:0]      event_res_o
);

  // configuration
  logic [shs_pkg::CfgW-1:0] beat_ivl_q;
  logic [shs_pkg::ThrW-1:0] trig_thr_q, scan_thr_q, goto_thr_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      beat_ivl_q <= shs_pkg::BEAT_INTERVAL_RST;
      trig_thr_q <= shs_pkg::TRIG_THR_RST;
      scan_thr_q <= shs_pkg::SCAN_THR_RST;
      goto_thr_q <= shs_pkg::GOTO_THR_RST;
    end else if (cfg_we_i) begin
      case (shs_pkg::reg_idx_e'(cfg_idx_i))
        shs_pkg::REG_BEAT_INTERVAL: beat_ivl_q <= cfg_wdata_i;
        shs_pkg::REG_TRIG_TIMEOUT:  trig_thr_q <= shs_pkg::to_ms(cfg_wdata_i);
        shs_pkg::REG_SCAN_TIMEOUT:  scan_thr_q <= shs_pkg::to_ms(cfg_wdata_i);
        shs_pkg::REG_GOTO_TIMEOUT:  goto_thr_q <= shs_pkg::to_ms(cfg_wdata_i);
        default: ;
      endcase
    end
  end

  // input register
  logic                        s1_valid_q;
  logic [shs_pkg::FuncW-1:0]   s1_func_q;
  logic                        s1_flag_q;
  logic [shs_pkg::TgtW-1:0]    s1_tgt_q;
  logic                        out_ready;
  logic                        adv;
  logic                        s1_load;

  assign out_ready  = !out_valid_o || !out_stall_i;
  assign adv        = s1_valid_q && out_ready;
  assign in_stall_o = s1_valid_q && !out_ready;
  assign s1_load    = in_valid_i && !in_stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (s1_load) begin
      s1_valid_q <= 1'b1;
    end else if (adv) begin
      s1_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_load) begin
      s1_func_q <= func_i;
      s1_flag_q <= status_flag_i;
      s1_tgt_q  <= goto_value_i;
    end
  end

  // supervisor state
  logic                        trig_q, trig_d;
  logic                        run_q, run_d;
  logic                        stmr_q, stmr_d;
  logic                        gtmr_q, gtmr_d;
  logic [shs_pkg::ElapW-1:0]   sel_q, sel_d;
  logic [shs_pkg::ElapW-1:0]   gel_q, gel_d;
  logic                        beat_q, beat_d;
  logic                        sen_q, sen_d;
  logic                        gen_q, gen_d;
  logic [shs_pkg::TgtW-1:0]    tgt_q, tgt_d;
  logic                        send_d;
  shs_pkg::evt_e               evt_d;
  shs_pkg::phase_e             phase_d;

  logic [shs_pkg::ElapW:0]     s_sum, g_sum;
  logic [shs_pkg::ElapW-1:0]   s_sat, g_sat;

  always_comb begin
    trig_d  = trig_q;
    run_d   = run_q;
    stmr_d  = stmr_q;
    gtmr_d  = gtmr_q;
    sel_d   = sel_q;
    gel_d   = gel_q;
    beat_d  = beat_q;
    sen_d   = sen_q;
    gen_d   = gen_q;
    tgt_d   = tgt_q;
    send_d  = 1'b0;
    evt_d   = shs_pkg::EV_NONE;
    s_sum   = {1'b0, sel_q} + (shs_pkg::ElapW+1)'(beat_ivl_q);
    g_sum   = {1'b0, gel_q} + (shs_pkg::ElapW+1)'(beat_ivl_q);
    s_sat   = s_sum[shs_pkg::ElapW] ? '1 : s_sum[shs_pkg::ElapW-1:0];
    g_sat   = g_sum[shs_pkg::ElapW] ? '1 : g_sum[shs_pkg::ElapW-1:0];
    case (shs_pkg::func_e'(s1_func_q))
      shs_pkg::FUNC_START: begin
        stmr_d = 1'b1;
        sel_d  = '0;
        trig_d = 1'b1;
        run_d  = 1'b0;
        beat_d = 1'b1;
        sen_d  = 1'b1;
        send_d = 1'b1;
      end
      shs_pkg::FUNC_GOTO: begin
        if (!trig_q && !run_q) begin
          gel_d  = '0;
          gtmr_d = 1'b1;
          sel_d  = '0;
          beat_d = 1'b1;
          gen_d  = 1'b1;
          tgt_d  = s1_tgt_q;
          send_d = 1'b1;
        end else begin
          evt_d = shs_pkg::EV_GOTO_REJECTED;
        end
      end
      shs_pkg::FUNC_SCAN_TICK: begin
        if (stmr_q) begin
          sel_d  = s_sat;
          send_d = 1'b1;
          if ((s_sat > shs_pkg::ElapW'(trig_thr_q)) && !run_q && trig_q) begin
            // drop the scan: no acknowledge in time
            trig_d = 1'b0;
            run_d  = 1'b0;
            stmr_d = 1'b0;
            beat_d = 1'b0;
            sen_d  = 1'b0;
            evt_d  = shs_pkg::EV_TRIG_TIMEOUT;
          end else if ((s_sat > shs_pkg::ElapW'(scan_thr_q)) && run_q && trig_q) begin
            trig_d = 1'b0;
            run_d  = 1'b0;
            stmr_d = 1'b0;
            beat_d = 1'b0;
            sen_d  = 1'b0;
            evt_d  = shs_pkg::EV_SCAN_TIMEOUT;
          end else begin
            beat_d = !beat_q;
          end
        end
      end
      shs_pkg::FUNC_GOTO_TICK: begin
        if (gtmr_q) begin
          send_d = 1'b1;
          if (gel_q < shs_pkg::ElapW'(goto_thr_q)) begin
            gel_d  = g_sat;
            beat_d = !beat_q;
          end else begin
            gtmr_d = 1'b0;
            beat_d = 1'b0;
            gen_d  = 1'b0;
            evt_d  = shs_pkg::EV_GOTO_ENDED;
          end
        end
      end
      shs_pkg::FUNC_STATUS: begin
        if (trig_q && !run_q && s1_flag_q) begin
          run_d = 1'b1;
          evt_d = shs_pkg::EV_STARTED;
        end else if (trig_q && run_q && !s1_flag_q) begin
          trig_d = 1'b0;
          run_d  = 1'b0;
          stmr_d = 1'b0;
          beat_d = 1'b0;
          sen_d  = 1'b0;
          send_d = 1'b1;
          evt_d  = shs_pkg::EV_COMPLETED;
        end
      end
      default: ;
    endcase
    if (run_d) begin
      phase_d = shs_pkg::PH_RUNNING;
    end else if (trig_d) begin
      phase_d = shs_pkg::PH_TRIGGERED;
    end else begin
      phase_d = shs_pkg::PH_IDLE;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      trig_q <= 1'b0;
      run_q  <= 1'b0;
      stmr_q <= 1'b0;
      gtmr_q <= 1'b0;
      sel_q  <= '0;
      gel_q  <= '0;
      beat_q <= 1'b0;
      sen_q  <= 1'b0;
      gen_q  <= 1'b0;
      tgt_q  <= '0;
    end else if (adv) begin
      trig_q <= trig_d;
      run_q  <= run_d;
      stmr_q <= stmr_d;
      gtmr_q <= gtmr_d;
      sel_q  <= sel_d;
      gel_q  <= gel_d;
      beat_q <= beat_d;
      sen_q  <= sen_d;
      gen_q  <= gen_d;
      tgt_q  <= tgt_d;
    end
  end

  // result register
  logic                         out_valid_q;
  logic                         send_q, hb_q, sen_out_q, gen_out_q;
  logic [shs_pkg::TgtW-1:0]     tgt_out_q;
  logic [shs_pkg::PhaseW-1:0]   phase_q;
  logic [shs_pkg::EvtW-1:0]     evt_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_ready) begin
      out_valid_q <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      send_q    <= send_d;
      hb_q      <= beat_d;
      sen_out_q <= sen_d;
      gen_out_q <= gen_d;
      tgt_out_q <= tgt_d;
      phase_q   <= phase_d;
      evt_q     <= evt_d;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign send_telegram_o = send_q;
  assign heartbeat_bit_o = hb_q;
  assign scan_enable_o   = sen_out_q;
  assign goto_enable_o   = gen_out_q;
  assign goto_target_o   = tgt_out_q;
  assign phase_o         = phase_q;
  assign event_res_o     = evt_q;

`ifndef SYNTH
  a_run_implies_trig: assert property (@(posedge clk_i) disable iff (!rst_ni)
    run_q |-> trig_q)
    else $error("scan running without trigger");

  a_scan_en_timer: assert property (@(posedge clk_i) disable iff (!rst_ni)
    sen_q == stmr_q)
    else $error("scan enable and scan timer disagree");

  a_goto_en_timer: assert property (@(posedge clk_i) disable iff (!rst_ni)
    gen_q == gtmr_q)
    else $error("go-to enable and go-to timer disagree");

  a_started_no_send: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && (event_res_o == shs_pkg::EV_STARTED)) |-> !send_telegram_o)
    else $error("telegram sent on scan start event");

  a_stall_needs_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (s1_valid_q && out_valid_q))
    else $error("input stalled with no pending beat");
`endif

endmodule

FILE: bench/shs_telegram_checker.sv
// ----------------------------------------------------------------------------
// shs_telegram_checker: command telegram predictor and scoreboard
// Follows the register writes and both beat channels of the supervisor,
// works out the telegram, phase and event that each accepted command beat
// must produce, and compares each result beat field by field with the
// oldest outstanding prediction.
// ----------------------------------------------------------------------------
module shs_telegram_checker (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [shs_pkg::CfgIdxW-1:0]   cfg_idx_i,
  input  logic [shs_pkg::CfgW-1:0]      cfg_wdata_i,
  input  logic                          in_valid_i,
  input  logic                          in_stall_i,
  input  logic [shs_pkg::FuncW-1:0]     func_i,
  input  logic                          status_flag_i,
  input  logic [shs_pkg::TgtW-1:0]      goto_value_i,
  input  logic                          out_valid_i,
  input  logic                          out_stall_i,
  input  logic                          send_telegram_i,
  input  logic                          heartbeat_bit_i,
  input  logic                          scan_enable_i,
  input  logic                          goto_enable_i,
  input  logic [shs_pkg::TgtW-1:0]      goto_target_i,
  input  logic [shs_pkg::PhaseW-1:0]    phase_i,
  input  logic [shs_pkg::EvtW-1:0]      event_res_i,
  output int                            telegrams_pending_o,
  output int                            fail_count_o
);

  typedef struct packed {
    logic                     send;
    logic                     beat;
    logic                     scan_en;
    logic                     goto_en;
    logic [shs_pkg::TgtW-1:0] target;
    shs_pkg::phase_e          phase;
    shs_pkg::evt_e            evt;
  } telegram_t;

  logic [shs_pkg::CfgW-1:0]  interval_ms;
  logic [shs_pkg::CfgW-1:0]  trig_s;
  logic [shs_pkg::CfgW-1:0]  scan_s;
  logic [shs_pkg::CfgW-1:0]  goto_s;

  logic                      armed;
  logic                      running;
  logic                      scan_clock_on;
  logic                      goto_clock_on;
  logic [shs_pkg::ElapW-1:0] scan_ms;
  logic [shs_pkg::ElapW-1:0] goto_ms;
  logic                      beat;
  logic                      scan_en;
  logic                      goto_en;
  logic [shs_pkg::TgtW-1:0]  target;

  telegram_t        expected_telegrams[$];
  int               mismatch_count = 0;

  assign fail_count_o = mismatch_count;

  task automatic report_mismatch(input string msg);
    $display("%0t: mismatch: %s", $time, msg);
    mismatch_count++;
  endtask

  function automatic logic [shs_pkg::ElapW-1:0] sat_sum(
      input logic [shs_pkg::ElapW-1:0] a, input logic [shs_pkg::CfgW-1:0] b);
    logic [shs_pkg::ElapW:0] sum;
    sum = {1'b0, a} + (shs_pkg::ElapW + 1)'(b);
    return sum[shs_pkg::ElapW] ? '1 : sum[shs_pkg::ElapW-1:0];
  endfunction

  function automatic logic [shs_pkg::ElapW-1:0] secs_to_ms(
      input logic [shs_pkg::CfgW-1:0] secs);
    return shs_pkg::ElapW'(secs) * shs_pkg::ElapW'(shs_pkg::MS_PER_S);
  endfunction

  function automatic void drop_scan();
    running       = 1'b0;
    armed         = 1'b0;
    scan_clock_on = 1'b0;
    beat          = 1'b0;
    scan_en       = 1'b0;
  endfunction

  function automatic telegram_t next_telegram(input logic [shs_pkg::FuncW-1:0] f,
                                              input logic flag,
                                              input logic [shs_pkg::TgtW-1:0] val);
    telegram_t t;
    t.send = 1'b0;
    t.evt  = shs_pkg::EV_NONE;
    case (f)
      shs_pkg::FUNC_START: begin
        scan_clock_on = 1'b1;
        scan_ms       = '0;
        armed         = 1'b1;
        running       = 1'b0;
        beat          = 1'b1;
        scan_en       = 1'b1;
        t.send        = 1'b1;
      end
      shs_pkg::FUNC_GOTO: begin
        if (!armed && !running) begin
          goto_ms       = '0;
          goto_clock_on = 1'b1;
          scan_ms       = '0;
          beat          = 1'b1;
          goto_en       = 1'b1;
          target        = val;
          t.send        = 1'b1;
        end else begin
          t.evt = shs_pkg::EV_GOTO_REJECTED;
        end
      end
      shs_pkg::FUNC_SCAN_TICK: begin
        if (scan_clock_on) begin
          scan_ms = sat_sum(scan_ms, interval_ms);
          t.send  = 1'b1;
          if (scan_ms > secs_to_ms(trig_s) && !running && armed) begin
            drop_scan();
            t.evt = shs_pkg::EV_TRIG_TIMEOUT;
          end else if (scan_ms > secs_to_ms(scan_s) && running && armed) begin
            drop_scan();
            t.evt = shs_pkg::EV_SCAN_TIMEOUT;
          end else begin
            beat = ~beat;
          end
        end
      end
      shs_pkg::FUNC_GOTO_TICK: begin
        if (goto_clock_on) begin
          t.send = 1'b1;
          if (goto_ms < secs_to_ms(goto_s)) begin
            goto_ms = sat_sum(goto_ms, interval_ms);
            beat    = ~beat;
          end else begin
            goto_clock_on = 1'b0;
            beat          = 1'b0;
            goto_en       = 1'b0;
            t.evt         = shs_pkg::EV_GOTO_ENDED;
          end
        end
      end
      shs_pkg::FUNC_STATUS: begin
        if (armed && !running && flag) begin
          running = 1'b1;
          t.evt   = shs_pkg::EV_STARTED;
        end else if (armed && running && !flag) begin
          drop_scan();
          t.send = 1'b1;
          t.evt  = shs_pkg::EV_COMPLETED;
        end
      end
      default: ;
    endcase
    t.beat    = beat;
    t.scan_en = scan_en;
    t.goto_en = goto_en;
    t.target  = target;
    t.phase   = running ? shs_pkg::PH_RUNNING :
                (armed ? shs_pkg::PH_TRIGGERED : shs_pkg::PH_IDLE);
    return t;
  endfunction

  task automatic compare_telegram(input telegram_t want);
    if (send_telegram_i !== want.send)
      report_mismatch($sformatf("send_telegram got %0d want %0d", send_telegram_i, want.send));
    if (heartbeat_bit_i !== want.beat)
      report_mismatch($sformatf("heartbeat_bit got %0d want %0d", heartbeat_bit_i, want.beat));
    if (scan_enable_i !== want.scan_en)
      report_mismatch($sformatf("scan_enable got %0d want %0d", scan_enable_i, want.scan_en));
    if (goto_enable_i !== want.goto_en)
      report_mismatch($sformatf("goto_enable got %0d want %0d", goto_enable_i, want.goto_en));
    if (goto_target_i !== want.target)
      report_mismatch($sformatf("goto_target got %0h want %0h", goto_target_i, want.target));
    if (phase_i !== want.phase)
      report_mismatch($sformatf("phase got %0d want %0d", phase_i, want.phase));
    if (event_res_i !== want.evt)
      report_mismatch($sformatf("event_res got %0d want %0d", event_res_i, want.evt));
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      interval_ms   = shs_pkg::BEAT_INTERVAL_RST;
      trig_s        = 16'd10;
      scan_s        = 16'd600;
      goto_s        = 16'd10;
      armed         = 1'b0;
      running       = 1'b0;
      scan_clock_on = 1'b0;
      goto_clock_on = 1'b0;
      scan_ms       = '0;
      goto_ms       = '0;
      beat          = 1'b0;
      scan_en       = 1'b0;
      goto_en       = 1'b0;
      target        = '0;
      expected_telegrams.delete();
      telegrams_pending_o <= 0;
    end else begin
      if (cfg_we_i) begin
        case (shs_pkg::reg_idx_e'(cfg_idx_i))
          shs_pkg::REG_BEAT_INTERVAL: interval_ms = cfg_wdata_i;
          shs_pkg::REG_TRIG_TIMEOUT:  trig_s      = cfg_wdata_i;
          shs_pkg::REG_SCAN_TIMEOUT:  scan_s      = cfg_wdata_i;
          shs_pkg::REG_GOTO_TIMEOUT:  goto_s      = cfg_wdata_i;
          default: ;
        endcase
      end
      if (out_valid_i && !out_stall_i) begin
        if (expected_telegrams.size() == 0) report_mismatch("result beat with none outstanding");
        else compare_telegram(expected_telegrams.pop_front());
      end
      if (in_valid_i && !in_stall_i)
        expected_telegrams.push_back(next_telegram(func_i, status_flag_i, goto_value_i));
      telegrams_pending_o <= expected_telegrams.size();
    end
  end

endmodule

FILE: bench/scan_heartbeat_supervisor_tb.sv
// ----------------------------------------------------------------------------
// scan_heartbeat_supervisor_tb: supervisor regression
// Drives a short directed set of commands covering every function, the
// scan start, normal end, both scan timeouts, go-to rejection and end and
// ignored commands, then weighted random command streams under several
// register settings and idling mixes. A separate checker predicts and
// scores every result beat; this top only drives and gives the verdict.
// ----------------------------------------------------------------------------
module scan_heartbeat_supervisor_tb;

  localparam int CycleLimit = 300000;
  localparam int RandomBeats = 184;

  logic                        clk = 1'b0;
  logic                        rst_n = 1'b0;
  logic                        cfg_we = 1'b0;
  logic [shs_pkg::CfgIdxW-1:0] cfg_idx = '0;
  logic [shs_pkg::CfgW-1:0]    cfg_wdata = '0;
  logic                        in_valid = 1'b0;
  logic                        in_stall;
  logic [shs_pkg::FuncW-1:0]   func = '0;
  logic                        status_flag = 1'b0;
  logic [shs_pkg::TgtW-1:0]    goto_value = '0;
  logic                        out_valid;
  logic                        out_stall = 1'b0;
  logic                        send_telegram;
  logic                        heartbeat_bit;
  logic                        scan_enable;
  logic                        goto_enable;
  logic [shs_pkg::TgtW-1:0]    goto_target;
  logic [shs_pkg::PhaseW-1:0]  phase;
  logic [shs_pkg::EvtW-1:0]    event_res;
  int                          telegrams_pending;
  int                          fail_count;
  int                          send_idle_pct = 29;
  int                          stall_pct = 84;
  int                          cycle_count = 0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  scan_heartbeat_supervisor dut (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .cfg_we_i       (cfg_we),
    .cfg_idx_i      (cfg_idx),
    .cfg_wdata_i    (cfg_wdata),
    .in_valid_i     (in_valid),
    .in_stall_o     (in_stall),
    .func_i         (func),
    .status_flag_i  (status_flag),
    .goto_value_i   (goto_value),
    .out_valid_o    (out_valid),
    .out_stall_i    (out_stall),
    .send_telegram_o(send_telegram),
    .heartbeat_bit_o(heartbeat_bit),
    .scan_enable_o  (scan_enable),
    .goto_enable_o  (goto_enable),
    .goto_target_o  (goto_target),
    .phase_o        (phase),
    .event_res_o    (event_res)
  );

  shs_telegram_checker telegram_check (
    .clk_i              (clk),
    .rst_ni             (rst_n),
    .cfg_we_i           (cfg_we),
    .cfg_idx_i          (cfg_idx),
    .cfg_wdata_i        (cfg_wdata),
    .in_valid_i         (in_valid),
    .in_stall_i         (in_stall),
    .func_i             (func),
    .status_flag_i      (status_flag),
    .goto_value_i       (goto_value),
    .out_valid_i        (out_valid),
    .out_stall_i        (out_stall),
    .send_telegram_i    (send_telegram),
    .heartbeat_bit_i    (heartbeat_bit),
    .scan_enable_i      (scan_enable),
    .goto_enable_i      (goto_enable),
    .goto_target_i      (goto_target),
    .phase_i            (phase),
    .event_res_i        (event_res),
    .telegrams_pending_o(telegrams_pending),
    .fail_count_o       (fail_count)
  );

  always @(posedge clk) out_stall <= ($urandom_range(0, 99) < stall_pct);

  initial begin
    while (cycle_count < CycleLimit) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("Regression FAIL");
    $finish;
  end

  task automatic send_command(input logic [shs_pkg::FuncW-1:0] f, input logic flag,
                              input logic [shs_pkg::TgtW-1:0] val);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid    <= 1'b1;
    func        <= f;
    status_flag <= flag;
    goto_value  <= val;
    do @(posedge clk); while (in_stall);
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    do @(posedge clk); while (telegrams_pending != 0);
  endtask

  task automatic write_reg(input shs_pkg::reg_idx_e idx,
                           input logic [shs_pkg::CfgW-1:0] val);
    cfg_we    <= 1'b1;
    cfg_idx   <= idx;
    cfg_wdata <= val;
    @(posedge clk);
  endtask

  task automatic load_settings(input logic [shs_pkg::CfgW-1:0] interval,
                               input logic [shs_pkg::CfgW-1:0] trig,
                               input logic [shs_pkg::CfgW-1:0] scan,
                               input logic [shs_pkg::CfgW-1:0] gto);
    write_reg(shs_pkg::REG_BEAT_INTERVAL, interval);
    write_reg(shs_pkg::REG_TRIG_TIMEOUT, trig);
    write_reg(shs_pkg::REG_SCAN_TIMEOUT, scan);
    write_reg(shs_pkg::REG_GOTO_TIMEOUT, gto);
    cfg_we <= 1'b0;
  endtask

  task automatic set_idling(input int send_pct, input int recv_pct);
    send_idle_pct <= send_pct;
    stall_pct     <= recv_pct;
  endtask

  task automatic run_random(input int beats);
    int pick;
    logic [shs_pkg::FuncW-1:0] f;
    for (int i = 0; i < beats; i++) begin
      pick = $urandom_range(0, 99);
      if (pick < 6) f = shs_pkg::FUNC_START;
      else if (pick < 14) f = shs_pkg::FUNC_GOTO;
      else if (pick < 44) f = shs_pkg::FUNC_SCAN_TICK;
      else if (pick < 72) f = shs_pkg::FUNC_GOTO_TICK;
      else if (pick < 94) f = shs_pkg::FUNC_STATUS;
      else f = shs_pkg::FuncW'($urandom_range(int'(shs_pkg::FUNC_STATUS) + 1,
                                              (1 << shs_pkg::FuncW) - 1));
      send_command(f, 1'($urandom_range(0, 1)), shs_pkg::TgtW'($urandom));
    end
  endtask

  initial begin
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // ignored commands, go-to beat, scan start and normal end under reset values
    send_command(shs_pkg::FUNC_STATUS, 1'b1, '0);
    send_command(shs_pkg::FUNC_SCAN_TICK, 1'b0, '0);
    send_command(shs_pkg::FUNC_GOTO_TICK, 1'b0, '0);
    for (int f = int'(shs_pkg::FUNC_STATUS) + 1; f < (1 << shs_pkg::FuncW); f++)
      send_command(shs_pkg::FuncW'(f), 1'b1, '1);
    send_command(shs_pkg::FUNC_GOTO, 1'b0, '1);
    send_command(shs_pkg::FUNC_GOTO_TICK, 1'b0, '0);
    send_command(shs_pkg::FUNC_SCAN_TICK, 1'b0, '0);
    send_command(shs_pkg::FUNC_START, 1'b0, '0);
    send_command(shs_pkg::FUNC_GOTO, 1'b0, '0);
    send_command(shs_pkg::FUNC_STATUS, 1'b0, '0);
    send_command(shs_pkg::FUNC_STATUS, 1'b1, '0);
    send_command(shs_pkg::FUNC_STATUS, 1'b1, '0);
    send_command(shs_pkg::FUNC_SCAN_TICK, 1'b0, '0);
    send_command(shs_pkg::FUNC_STATUS, 1'b0, '0);
    send_command(shs_pkg::FUNC_GOTO, 1'b0, '0);
    wait_drained();

    // timeouts at zero with the largest interval
    load_settings('1, '0, '0, '0);
    send_command(shs_pkg::FUNC_START, 1'b0, '0);
    send_command(shs_pkg::FUNC_SCAN_TICK, 1'b0, '0);
    send_command(shs_pkg::FUNC_START, 1'b0, '0);
    send_command(shs_pkg::FUNC_STATUS, 1'b1, '0);
    send_command(shs_pkg::FUNC_SCAN_TICK, 1'b0, '0);
    send_command(shs_pkg::FUNC_GOTO_TICK, 1'b0, '0);
    send_command(shs_pkg::FUNC_GOTO_TICK, 1'b0, '0);
    wait_drained();

    load_settings(16'd1000, 16'd3, 16'd6, 16'd4);
    run_random(RandomBeats);
    wait_drained();

    set_idling(84, 29);
    load_settings('1, '0, '1, 16'd1);
    run_random(RandomBeats);
    wait_drained();

    set_idling(0, 0);
    load_settings(16'd1, '1, '0, '0);
    run_random(RandomBeats);
    wait_drained();

    repeat (8) @(posedge clk);
    if (fail_count == 0) $display("Regression PASS");
    else $display("Regression FAIL");
    $finish;
  end

endmodule
